>>> hdl/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checksummed frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Frame delimiter bytes
  localparam logic [7:0] HDR_P     = 8'h50;
  localparam logic [7:0] HDR_D     = 8'h44;
  localparam logic [7:0] HDR_C     = 8'h43;
  localparam logic [7:0] SEP_COLON = 8'h3A;

  // Timeout register
  localparam int unsigned TICK_W = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_D     = 3'd1,
    PH_C1    = 3'd2,
    PH_C2    = 3'd3,
    PH_LEN   = 3'd4,
    PH_COLON = 3'd5,
    PH_CMD   = 3'd6,
    PH_BODY  = 3'd7
  } phase_t;

  // One input item
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  // One result item
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  command;
    logic [7:0]  data;
    logic [7:0]  pos;
  } result_t;

endpackage

>>> hdl/xcfp_core.sv
// ----------------------------------------------------------------------------
// xcfp_core
// Parser state and per-item next-state logic; produces zero or one result
// for each item that advances.
// ----------------------------------------------------------------------------
module xcfp_core import xcfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic              item_fire,
  input  item_t             item,
  output logic              res_emit,
  output result_t           res
);

  logic [TICK_W-1:0] timeout_ticks;
  phase_t            phase, phase_next;
  logic [7:0]        frame_length, frame_length_next;
  logic [7:0]        frame_command, frame_command_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [7:0]        payload_count, payload_count_next;
  logic              timeout_armed, timeout_armed_next;
  logic [TICK_W-1:0] timeout_count, timeout_count_next;
  logic [TICK_W-1:0] count_inc;
  logic [7:0]        b;

  assign b = item.data_byte;
  // Saturating tick count
  assign count_inc = (timeout_count == TICK_MAX) ? timeout_count
                                                 : timeout_count + 1'b1;

  // Next state and result for the current item
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    frame_command_next = frame_command;
    running_xor_next   = running_xor;
    payload_count_next = payload_count;
    timeout_armed_next = timeout_armed;
    timeout_count_next = timeout_count;
    res_emit           = 1'b0;
    res.kind           = EV_PAYLOAD;
    res.command        = frame_command;
    res.data           = 8'd0;
    res.pos            = 8'd0;

    if (item.action == ACT_TICK) begin
      if (timeout_armed) begin
        timeout_count_next = count_inc;
        if (count_inc >= timeout_ticks) begin
          timeout_armed_next = 1'b0;
          timeout_count_next = '0;
          phase_next         = PH_HUNT;
          res_emit           = 1'b1;
          res.kind           = EV_TIMEOUT;
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == HDR_P) begin
            timeout_armed_next = 1'b1;
            running_xor_next   = b;
            phase_next         = PH_D;
          end
        end
        PH_D: begin
          if (b == HDR_D) begin
            running_xor_next = running_xor ^ b;
            phase_next       = PH_C1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_C1, PH_C2: begin
          if (b == HDR_C) begin
            running_xor_next = running_xor ^ b;
            phase_next       = (phase == PH_C1) ? PH_C2 : PH_LEN;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN: begin
          frame_length_next = b;
          running_xor_next  = running_xor ^ b;
          phase_next        = PH_COLON;
        end
        PH_COLON: begin
          if (b == SEP_COLON) begin
            running_xor_next = running_xor ^ b;
            phase_next       = PH_CMD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_CMD: begin
          frame_command_next = b;
          running_xor_next   = running_xor ^ b;
          payload_count_next = 8'd0;
          phase_next         = PH_BODY;
        end
        PH_BODY: begin
          res_emit = 1'b1;
          if (payload_count == frame_length) begin
            // Checksum byte closes the frame
            res.kind           = (running_xor == b) ? EV_GOOD : EV_BAD;
            res.pos            = frame_length;
            timeout_armed_next = 1'b0;
            timeout_count_next = '0;
            phase_next         = PH_HUNT;
          end else begin
            running_xor_next   = running_xor ^ b;
            res.kind           = EV_PAYLOAD;
            res.data           = b;
            res.pos            = payload_count;
            payload_count_next = payload_count + 8'd1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Timeout limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Advance parser state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= 8'd0;
      frame_command <= 8'd0;
      running_xor   <= 8'd0;
      payload_count <= 8'd0;
      timeout_armed <= 1'b0;
      timeout_count <= '0;
    end else if (item_fire) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      frame_command <= frame_command_next;
      running_xor   <= running_xor_next;
      payload_count <= payload_count_next;
      timeout_armed <= timeout_armed_next;
      timeout_count <= timeout_count_next;
    end
  end

endmodule

>>> hdl/xor_checksum_frame_parser_top.sv
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_top
// Deframes 'PDCC' frames with an XOR checksum from a stream of bytes and
// millisecond ticks; reports payload bytes, frame status and timeouts.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   action, data_byte
//   out      output     out_valid/out_stall event_kind, command_code,
//                                           payload_data, byte_position
//   cfg      input      cfg_valid/cfg_ready cfg_data (timeout_ticks)
//
// An item is captured in the input register, then the parser state and the
// result register are updated when it has room: one item per cycle is
// sustained unless stalled. The input stalls only while the input register
// holds an item and the result register is full and stalled downstream.
// Reset (rst, synchronous) returns to the header hunt with a limit of 500.
// ----------------------------------------------------------------------------
module xor_checksum_frame_parser_top import xcfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic [7:0]        command_code,
  output logic [7:0]        payload_data,
  output logic [7:0]        byte_position,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TICK_W-1:0] cfg_data
);

  logic    in_reg_valid;
  item_t   in_reg;
  logic    advance;
  logic    res_emit;
  result_t res, res_reg;

  // Result register can take a new value when empty or being drained
  assign advance  = in_reg_valid && !(out_valid && out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg.action    <= action;
      in_reg.data_byte <= data_byte;
    end
  end

  xcfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .item_fire (advance),
    .item      (in_reg),
    .res_emit  (res_emit),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_emit) begin
      res_reg <= res;
    end
  end

  assign event_kind    = res_reg.kind;
  assign command_code  = res_reg.command;
  assign payload_data  = res_reg.data;
  assign byte_position = res_reg.pos;

endmodule
